FILE: hdl/acsa_pkg.sv
// Package: shared types, codes and sizes for the ADC channel sum accumulator.
package acsa_pkg;

   localparam int unsigned NUM_PINS      = 32;
   localparam int unsigned SAMPLE_BITS   = 12;
   localparam int unsigned PIN_ADDR_BITS = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

   localparam int unsigned PIN_W    = 5;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned GAIN_W   = 32;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned SUM_W    = 64;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned LEN_W    = 16;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_REGULAR  = 2'd1;
   localparam logic [1:0] OP_INJECTED = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   localparam logic [1:0] GRP_UNUSED   = 2'd0;
   localparam logic [1:0] GRP_REGULAR  = 2'd1;
   localparam logic [1:0] GRP_INJECTED = 2'd2;

   localparam logic OUT_GRP_REGULAR  = 1'b0;
   localparam logic OUT_GRP_INJECTED = 1'b1;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LEN_REGULAR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LEN_INJECTED = 1'd1;
   localparam logic [LEN_W-1:0] CYCLE_LEN_RESET = 16'd256;

   localparam int unsigned Q_PTR_W = 1;
   localparam int unsigned Q_CNT_W = 2;
   localparam logic [Q_CNT_W-1:0] Q_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic [PIN_W-1:0]           pin;
      logic [SAMPLE_W-1:0]        sample;
      logic [1:0]                 set_group;
      logic                       set_rms;
      logic signed [GAIN_W-1:0]   set_gain;
      logic signed [OFFSET_W-1:0] set_offset;
   } acsa_req_type;

   typedef struct packed {
      logic [PIN_W-1:0]        out_pin;
      logic                    out_group;
      logic signed [SUM_W-1:0] period_sum;
      logic [COUNT_W-1:0]      period_count;
   } acsa_rsp_type;

   // Classified item as it waits between front and back
   typedef struct packed {
      logic [1:0]                 kind;
      logic [PIN_ADDR_BITS-1:0]   addr;
      logic [SAMPLE_W-1:0]        sample;
      logic [1:0]                 group;
      logic                       rms;
      logic signed [GAIN_W-1:0]   gain;
      logic signed [OFFSET_W-1:0] offset;
   } acsa_entry_type;

   typedef struct packed {
      logic [1:0]                 group;
      logic                       rms;
      logic signed [GAIN_W-1:0]   gain;
      logic signed [OFFSET_W-1:0] offset;
   } acsa_set_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [COUNT_W-1:0]      count;
   } acsa_acc_type;

   typedef struct packed {
      logic           valid;
      acsa_entry_type entry;
   } acsa_queue_type;

endpackage

FILE: hdl/adc_channel_sum_accumulator.sv
// Top level: ADC channel sum accumulator, front end, queue and back end.
//
// Keeps group, rms flag, gain, offset and a running sum and count for each pin. The front end
// takes one request transfer per cycle into a two-entry queue while the queue has room; the back
// end sequencer runs idle, read, scale and accumulate (memory read, gain multiply, round/saturate
// and square, saturating accumulate); a load ends in idle, a skipped sample in read, and a plain
// sample skips scale. That sequencer and its registered memory read set the sustained rate.
// A completed period is held in an output register, so new requests are taken while a result
// waits. Pin state is cleared by per-pin valid bits at reset; no clearing pass is needed.
module adc_channel_sum_accumulator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  acsa_pkg::acsa_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output acsa_pkg::acsa_rsp_type           rsp_data,
   input  logic                             csr_we,
   input  logic [acsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acsa_pkg::LEN_W-1:0]       csr_wdata
);
   import acsa_pkg::*;

   acsa_queue_type q_head;
   logic           q_pop;

   acsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   acsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/acsa_front.sv
// Front end: accepts request transfers, classifies them and queues them for the back end.
module acsa_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  acsa_pkg::acsa_req_type      req_data,
   output acsa_pkg::acsa_queue_type    q_head,
   input  logic                        q_pop
);
   import acsa_pkg::*;

   acsa_entry_type             entry_ff [2];
   logic [Q_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]         count_ff, count_in;
   acsa_entry_type             cls;
   logic                       keep;
   logic                       push;

   always_comb begin
      cls.kind   = req_data.opcode;
      cls.addr   = PIN_ADDR_BITS'(req_data.pin);
      cls.sample = req_data.sample & SAMPLE_MASK;
      cls.rms    = req_data.set_rms;
      cls.gain   = req_data.set_gain;
      cls.offset = req_data.set_offset;
      case (req_data.set_group)
         GRP_REGULAR, GRP_INJECTED: cls.group = req_data.set_group;
         default:                   cls.group = GRP_UNUSED;
      endcase
   end

   assign keep      = (req_data.opcode != OP_NONE) && (32'(req_data.pin) < 32'(NUM_PINS));
   assign req_stall = (count_ff == Q_FULL);
   assign push      = req_valid && !req_stall && keep;

   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/acsa_back.sv
// Back end: pin memories, sequencer for scaling and accumulation, result register.
module acsa_back (
   input  logic                             clock,
   input  logic                             reset,
   input  acsa_pkg::acsa_queue_type         q_head,
   output logic                             q_pop,
   input  logic                             csr_we,
   input  logic [acsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acsa_pkg::LEN_W-1:0]       csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output acsa_pkg::acsa_rsp_type           rsp_data
);
   import acsa_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_SCALE = 2'd2;
   localparam logic [1:0] ST_ACC   = 2'd3;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [23:0]      V_MAX   = 24'sh7FFFFF;
   localparam logic signed [23:0]      V_MIN   = 24'sh800000;

   acsa_set_type               set_mem_ff [NUM_PINS];
   acsa_acc_type               acc_mem_ff [NUM_PINS];
   acsa_set_type               set_rd_ff;
   acsa_acc_type               acc_rd_ff;

   logic [1:0]                 state_ff, state_in;
   logic [NUM_PINS-1:0]        loaded_ff, loaded_in;
   acsa_entry_type             item_ff, item_in;
   logic signed [17:0]         diff_ff, diff_in;
   logic signed [49:0]         prod_ff, prod_in;
   logic signed [23:0]         v_ff, v_in;
   logic signed [47:0]         sq_ff, sq_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   acsa_rsp_type               rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]           len_reg_ff, len_reg_in;
   logic [LEN_W-1:0]           len_inj_ff, len_inj_in;

   logic                       rd_en;
   logic                       set_we;
   logic                       acc_we;
   logic [PIN_ADDR_BITS-1:0]   acc_waddr;
   acsa_acc_type               acc_wdata;
   acsa_set_type               set_wdata;

   logic                       is_regular;
   logic                       match;
   logic signed [17:0]         samp_s;
   logic signed [17:0]         off_s;
   logic signed [17:0]         diff_c;
   logic signed [50:0]         rnd;
   logic signed [34:0]         shv;
   logic signed [23:0]         v_sat;
   logic signed [SUM_W-1:0]    add_val;
   logic signed [SUM_W-1:0]    sum_raw;
   logic signed [SUM_W-1:0]    sum_sat;
   logic [COUNT_W-1:0]         cnt_new;
   logic [LEN_W-1:0]           len;
   logic                       hit;
   logic                       out_free;

   assign is_regular = (item_ff.kind == OP_REGULAR);
   assign match      = loaded_ff[item_ff.addr]
                       && (set_rd_ff.group == (is_regular ? GRP_REGULAR : GRP_INJECTED));

   assign samp_s = {6'd0, item_ff.sample};
   assign off_s  = {{2{set_rd_ff.offset[OFFSET_W-1]}}, set_rd_ff.offset};
   assign diff_c = samp_s - off_s;

   // Round half up then floor by 2^16, saturate to 24 bits
   assign rnd = {prod_ff[49], prod_ff} + 51'sd32768;
   assign shv = rnd[50:16];
   always_comb begin
      if (!shv[34] && (|shv[33:23])) begin
         v_sat = V_MAX;
      end else if (shv[34] && !(&shv[33:23])) begin
         v_sat = V_MIN;
      end else begin
         v_sat = shv[23:0];
      end
   end

   always_comb begin
      if (!set_rd_ff.rms) begin
         add_val = {{(SUM_W-18){diff_ff[17]}}, diff_ff};
      end else if (is_regular) begin
         add_val = {{(SUM_W-48){sq_ff[47]}}, sq_ff};
      end else begin
         add_val = {{(SUM_W-24){v_ff[23]}}, v_ff};
      end
   end

   assign sum_raw = acc_rd_ff.sum + add_val;
   always_comb begin
      if ((acc_rd_ff.sum[SUM_W-1] == add_val[SUM_W-1])
          && (sum_raw[SUM_W-1] != acc_rd_ff.sum[SUM_W-1])) begin
         sum_sat = acc_rd_ff.sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_raw;
      end
   end

   assign cnt_new  = acc_rd_ff.count + COUNT_W'(1);
   assign len      = is_regular ? len_reg_ff : len_inj_ff;
   assign hit      = (cnt_new >= len);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign set_wdata.group  = q_head.entry.group;
   assign set_wdata.rms    = q_head.entry.rms;
   assign set_wdata.gain   = q_head.entry.gain;
   assign set_wdata.offset = q_head.entry.offset;

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      item_in      = item_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      v_in         = v_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      set_we       = 1'b0;
      acc_we       = 1'b0;
      acc_waddr    = item_ff.addr;
      acc_wdata    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.entry.kind == OP_LOAD) begin
                  set_we                        = 1'b1;
                  acc_we                        = 1'b1;
                  acc_waddr                     = q_head.entry.addr;
                  loaded_in[q_head.entry.addr]  = 1'b1;
               end else begin
                  item_in  = q_head.entry;
                  rd_en    = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (!match) begin
               state_in = ST_IDLE;
            end else begin
               diff_in  = diff_c;
               prod_in  = diff_c * set_rd_ff.gain;
               state_in = set_rd_ff.rms ? ST_SCALE : ST_ACC;
            end
         end
         ST_SCALE: begin
            v_in     = v_sat;
            sq_in    = v_sat * v_sat;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (out_free) begin
               acc_we = 1'b1;
               if (hit) begin
                  acc_wdata                = '0;
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.out_pin      = PIN_W'(item_ff.addr);
                  rsp_data_in.out_group    = is_regular ? OUT_GRP_REGULAR : OUT_GRP_INJECTED;
                  rsp_data_in.period_sum   = sum_sat;
                  rsp_data_in.period_count = cnt_new;
               end else begin
                  acc_wdata.sum   = sum_sat;
                  acc_wdata.count = cnt_new;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      len_reg_in = len_reg_ff;
      len_inj_in = len_inj_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CYCLE_LEN_REGULAR:  len_reg_in = csr_wdata;
            CSR_CYCLE_LEN_INJECTED: len_inj_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (set_we) begin
         set_mem_ff[q_head.entry.addr] <= set_wdata;
      end
      if (rd_en) begin
         set_rd_ff <= set_mem_ff[q_head.entry.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem_ff[acc_waddr] <= acc_wdata;
      end
      if (rd_en) begin
         acc_rd_ff <= acc_mem_ff[q_head.entry.addr];
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      v_ff        <= v_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         len_reg_ff   <= CYCLE_LEN_RESET;
         len_inj_ff   <= CYCLE_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
         len_reg_ff   <= len_reg_in;
         len_inj_ff   <= len_inj_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/acsa_checker.sv
// Checker: port-level assertions for the ADC channel sum accumulator, bound to the top level.
module acsa_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input acsa_pkg::acsa_rsp_type  rsp_data
);
   import acsa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_reset_no_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_no_stall: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("request stalled right after reset");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("result appeared too soon after reset");

endmodule

bind adc_channel_sum_accumulator acsa_checker u_checker (.*);
